// ===== sv/ird_pkg.sv =====
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types, constants and the digit-to-character mapping for the
// integer-to-radix-digits converter.
// ----------------------------------------------------------------------------
package ird_pkg;

    // Width of the radix register and of one stored digit.
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 6'd9;

    // Status returned by the serial divider to the sequencer.
    typedef struct packed {
        logic done;         // one-cycle pulse when quotient and remainder are ready
        logic quotient_nz;  // quotient has at least one bit set
    } div_status_t;

    // Map a digit value 0..35 to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d > DIGIT_NINE)
            return CHAR_A + d_ext - {1'b0, DIGIT_TEN};
        else
            return CHAR_ZERO + d_ext;
    endfunction

endpackage

// ===== sv/ird_ram.sv =====
// ----------------------------------------------------------------------------
// ird_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ird_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ird_divider.sv =====
// ----------------------------------------------------------------------------
// ird_divider
// Bit-serial restoring divider: divides a VALUE_BITS-wide value by a small
// base, one quotient bit per cycle, and returns quotient and remainder.
// ----------------------------------------------------------------------------
module ird_divider
    import ird_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder,
    output div_status_t           status
);

    localparam int STEP_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic                  nz_reg, nz_next;

    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  ge;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge    = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        nz_next     = nz_reg;
        if (start)
        begin
            quo_next    = dividend;
            rem_next    = '0;
            step_next   = STEP_W'(VALUE_BITS - 1);
            active_next = 1'b1;
            nz_next     = 1'b0;
        end
        else if (active_reg)
        begin
            // The partial remainder stays below the divisor, so it fits DIGIT_W bits.
            rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            nz_next  = nz_reg | ge;
            if (step_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        nz_reg  <= nz_next;
    end

    assign quotient           = quo_reg;
    assign remainder          = rem_reg;
    assign status.done        = done_reg;
    assign status.quotient_nz = nz_reg;

endmodule

// ===== sv/integer_to_radix_digits_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts an unsigned value to ASCII digits in a programmable radix and
// emits them most significant first, flagging the last one.
// ----------------------------------------------------------------------------
// Each digit costs one full pass of the bit-serial divider, then the digits
// stream out of the digit RAM one per cycle. One item is in flight at a time;
// the next item is taken only once the sequencer is back in idle.
// Reset: radix returns to 10 and the sequencer goes idle. Results cannot stall.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core
    import ird_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [63:0]         number_in,
    input  logic                radix_wr_en,
    input  logic [RADIX_W-1:0]  radix_wr_data,
    output logic                digit_valid,
    output logic [CHAR_W-1:0]   digit_char,
    output logic                last_digit
);

    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic                 valid_reg, valid_next;
    logic                 last_reg, last_next;

    logic [RADIX_W-1:0]    eff_base;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;
    div_status_t           div_status;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [DIGIT_W-1:0]    ram_rd_data;
    logic [CNT_W-1:0]      cnt_minus_one;

    // Radix register; out-of-range codes are clamped when used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_wr_en)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            eff_base = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            eff_base = RADIX_MAX;
        else
            eff_base = radix_reg;
    end

    // The first pass divides the input value; later passes divide the quotient.
    assign div_dividend = (state_reg == ST_IDLE) ? number_in[VALUE_BITS-1:0] : div_quotient;

    ird_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_base),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    // Digits are stored least significant first and read back in reverse.
    assign cnt_minus_one = cnt_reg - 1'b1;
    assign ram_wr_addr   = cnt_reg[ADDR_W-1:0];
    assign ram_rd_addr   = cnt_minus_one[ADDR_W-1:0];

    ird_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (div_remainder),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer: repeated division, then readout of the stored digits.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        div_start  = 1'b0;
        ram_wr_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    div_start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    ram_wr_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (div_status.quotient_nz)
                        div_start = 1'b1;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                last_next  = (cnt_reg == CNT_W'(1));
                cnt_next   = cnt_minus_one;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // Result ports line up with the registered RAM read.
    assign busy        = (state_reg != ST_IDLE);
    assign digit_valid = valid_reg;
    assign last_digit  = last_reg;
    assign digit_char  = digit_to_char(ram_rd_data);

    // Checks on the sequencer and the emitted characters.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> ((digit_char >= CHAR_ZERO && digit_char <= CHAR_ZERO + 7'd9) ||
                         (digit_char >= CHAR_A && digit_char <= CHAR_A + 7'd25)))
        else $error("digit character out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_digit |-> digit_valid)
        else $error("last flag without a valid digit");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg != '0))
        else $error("readout started with no stored digits");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_radix_digits_core. A directed table of
// items covers the extremes of the value and the radix, including radix
// values outside 2..36. Random phases follow, each with a new radix. Every
// character is compared with the row's text or with a local base-conversion predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import ird_pkg::*;

    localparam int VALUE_BITS = 64;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT = 20000;
    localparam int MAX_REPORTS = 100;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int NO_IDLE_PHASE = 2;

    // One expected output character.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_exp_t;

    // One row of the directed table; an empty text means the predictor decides.
    typedef struct {
        bit                 wr;
        logic [RADIX_W-1:0] radix;
        logic [63:0]        value;
        string              text;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [63:0]        number_in = '0;
    logic               radix_wr_en = 1'b0;
    logic [RADIX_W-1:0] radix_wr_data = '0;
    logic               digit_valid;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;

    digit_exp_t         pending_digits[$];
    stim_row_t          directed_rows[$];
    logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
    int                 error_count = 0;
    int                 quiet_cycles = 0;

    integer_to_radix_digits_core #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .number_in    (number_in),
        .radix_wr_en  (radix_wr_en),
        .radix_wr_data(radix_wr_data),
        .digit_valid  (digit_valid),
        .digit_char   (digit_char),
        .last_digit   (last_digit)
    );

    always #1 clk = ~clk;

    // Print one line per mismatch, up to a cap, and count all of them.
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Convert a value in the current radix and queue its characters.
    function automatic void predict_digits(input logic [63:0] value);
        logic [63:0]        v;
        logic [63:0]        base;
        logic [63:0]        rem;
        logic [DIGIT_W-1:0] digits[64];
        int                 n;
        digit_exp_t         e;
        v = value & VALUE_MASK;
        base = {58'd0, radix_shadow};
        if (base < RADIX_MIN)
            base = RADIX_MIN;
        if (base > RADIX_MAX)
            base = RADIX_MAX;
        if (v == 0)
        begin
            e.ch = CHAR_ZERO;
            e.last = 1'b1;
            pending_digits.push_back(e);
            return;
        end
        n = 0;
        while (v != 0)
        begin
            rem = v % base;
            digits[n] = rem[DIGIT_W-1:0];
            v = v / base;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digits[k] > 9)
                e.ch = CHAR_A + CHAR_W'(digits[k]) - 7'd10;
            else
                e.ch = CHAR_ZERO + CHAR_W'(digits[k]);
            e.last = (k == 0);
            pending_digits.push_back(e);
        end
    endfunction

    // Queue characters that are known by inspection.
    function automatic void queue_text(input string text);
        digit_exp_t e;
        byte        c;
        for (int i = 0; i < text.len(); i++)
        begin
            c = text[i];
            e.ch = c[CHAR_W-1:0];
            e.last = (i == text.len() - 1);
            pending_digits.push_back(e);
        end
    endfunction

    function automatic void add_row(input bit wr, input logic [RADIX_W-1:0] radix,
                                    input logic [63:0] value, input string text);
        stim_row_t row;
        row.wr = wr;
        row.radix = radix;
        row.value = value;
        row.text = text;
        directed_rows.push_back(row);
    endfunction

    // Offer one item until the block takes it; when allowed, start drops at
    // random in about 31 of every hundred attempts.
    task automatic send_item(input logic [63:0] value, input string text,
                             input bit allow_idle);
        bit offer;
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            offer = !(allow_idle && $urandom_range(0, 99) < 31);
            start <= offer;
            number_in <= offer ? value : {$urandom, $urandom};
            @(posedge clk);
            taken = offer && !busy;
        end
        if (text.len() > 0)
            queue_text(text);
        else
            predict_digits(value);
    endtask

    // Write the radix once every pending character has come out.
    task automatic set_radix(input logic [RADIX_W-1:0] value);
        start <= 1'b0;
        while (pending_digits.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        radix_wr_en <= 1'b1;
        radix_wr_data <= value;
        @(posedge clk);
        radix_wr_en <= 1'b0;
        radix_shadow = value;
    endtask

    function automatic logic [RADIX_W-1:0] pick_radix();
        case ($urandom_range(0, 5))
            0: return RADIX_W'($urandom_range(0, 1));
            1: return RADIX_MIN;
            2: return RADIX_MAX;
            3: return RADIX_W'($urandom_range(37, 63));
            default: return RADIX_W'($urandom_range(2, 36));
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return {64{1'b1}};
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Compare every output character with the oldest expectation.
    always @(posedge clk)
    begin
        digit_exp_t e;
        if (rst_n && digit_valid)
        begin
            if (pending_digits.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%0h", digit_char));
            else
            begin
                e = pending_digits.pop_front();
                if (digit_char !== e.ch)
                    report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                              digit_char, e.ch));
                if (last_digit !== e.last)
                    report_mismatch($sformatf("last_digit %0b, expected %0b",
                                              last_digit, e.last));
            end
        end
    end

    // End the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || digit_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: directed table, then random phases, then drain.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first rows rely on the reset radix of ten.
        add_row(1'b0, 6'd10, 64'd0, "0");
        add_row(1'b0, 6'd10, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615");
        add_row(1'b0, 6'd10, 64'd9, "9");
        add_row(1'b0, 6'd10, 64'd10, "10");
        add_row(1'b1, 6'd2, 64'd1, "1");
        add_row(1'b1, 6'd2, 64'd0, "0");
        add_row(1'b0, 6'd2, 64'hFFFF_FFFF_FFFF_FFFF, "");
        add_row(1'b0, 6'd2, 64'h8000_0000_0000_0000, "");
        // Radix values below two act as base two.
        add_row(1'b1, 6'd0, 64'd5, "101");
        add_row(1'b1, 6'd1, 64'd6, "110");
        add_row(1'b1, 6'd16, 64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF");
        add_row(1'b0, 6'd16, 64'h0123_4567_89AB_CDEF, "123456789ABCDEF");
        add_row(1'b1, 6'd36, 64'd35, "Z");
        add_row(1'b0, 6'd36, 64'd36, "10");
        add_row(1'b0, 6'd36, 64'hFFFF_FFFF_FFFF_FFFF, "");
        // Radix values above thirty-six act as base thirty-six.
        add_row(1'b1, 6'd37, 64'd35, "Z");
        add_row(1'b1, 6'd63, 64'd71, "1Z");
        add_row(1'b0, 6'd63, 64'hFFFF_FFFF_FFFF_FFFE, "");
        // Odd and even bases need the remainder of the whole wide value.
        add_row(1'b1, 6'd3, 64'hFFFF_FFFF_FFFF_FFFF, "");
        add_row(1'b1, 6'd7, 64'hAAAA_AAAA_AAAA_AAAA, "");
        add_row(1'b1, 6'd8, 64'h8000_0000_0000_0000, "");
        add_row(1'b1, 6'd10, 64'hFFFF_FFFF_FFFF_FFFE, "");

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].wr)
                set_radix(directed_rows[i].radix);
            send_item(directed_rows[i].value, directed_rows[i].text, 1'b1);
        end

        // Each random phase starts from an idle block with a fresh radix.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_radix(pick_radix());
            for (int j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                send_item(pick_value(), "", p != NO_IDLE_PHASE);
            end
        end

        start <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_digits.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
